// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants of the contrast stretch and palette mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  // Item commands
  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_ON    = 3'd5;
  localparam int unsigned CFG_DATA_W = 8;

  // Ramp division: quotient of the biased numerator is below 512
  localparam int unsigned SUM_W     = 18;
  localparam int unsigned DIV_W     = 9;
  localparam int unsigned QUOT_BITS = 9;
  localparam int unsigned CNT_W     = 4;

  // Queue between front and back
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_DIRECT,
    KIND_RAMP
  } csp_kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] gray_level;
    logic       pixel_last;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } csp_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_last;
  } csp_out_t;

  typedef struct packed {
    logic       contrast_on;
    logic [7:0] contrast_low;
    logic [7:0] contrast_high;
    logic [7:0] out_low;
    logic [7:0] out_high;
    logic       palette_on;
  } csp_cfg_t;

  typedef struct packed {
    csp_kind_e        kind;
    logic [7:0]       level;
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
    logic [7:0]       out_low;
    logic             last;
    logic [7:0]       pal_index;
    logic [23:0]      pal_rgb;
  } csp_entry_t;

endpackage

`default_nettype wire

// ===== rtl/csp_ram.sv =====
// ----------------------------------------------------------------------------
// csp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/csp_front.sv =====
// ----------------------------------------------------------------------------
// csp_front
// Classify incoming items and precompute the ramp numerator and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_front (
  input  wire logic                push_i,
  input  wire csp_pkg::csp_in_t    item_i,
  input  wire csp_pkg::csp_cfg_t   cfg_i,
  input  wire logic                queue_full_i,
  output logic                     queue_push_o,
  output csp_pkg::csp_entry_t      entry_o
);
  import csp_pkg::*;

  logic [7:0]        den;
  logic [7:0]        diff_x;
  logic signed [8:0] span;
  logic signed [17:0] prod;
  logic [19:0]       sum_wide;

  assign den    = cfg_i.contrast_high - cfg_i.contrast_low;
  assign diff_x = item_i.gray_level - cfg_i.contrast_low;
  assign span   = $signed({1'b0, cfg_i.out_high}) - $signed({1'b0, cfg_i.out_low});
  assign prod   = $signed({1'b0, diff_x}) * span;

  // 2*num + 511*den, positive because |num| < 255*den inside the window
  assign sum_wide = {prod[17], prod, 1'b0} + {3'b000, den, 9'd0} - {12'd0, den};

  always_comb begin
    entry_o.level     = item_i.gray_level;
    entry_o.sum       = sum_wide[SUM_W-1:0];
    entry_o.divisor   = {den, 1'b0};
    entry_o.out_low   = cfg_i.out_low;
    entry_o.last      = item_i.pixel_last;
    entry_o.pal_index = item_i.palette_index;
    entry_o.pal_rgb   = {item_i.palette_red, item_i.palette_green, item_i.palette_blue};
    if (item_i.command == CMD_PAL_WRITE) begin
      entry_o.kind = KIND_WRITE;
    end else if (!cfg_i.contrast_on) begin
      entry_o.kind = KIND_DIRECT;
    end else if (item_i.gray_level <= cfg_i.contrast_low) begin
      entry_o.kind  = KIND_DIRECT;
      entry_o.level = cfg_i.out_low;
    end else if (item_i.gray_level >= cfg_i.contrast_high) begin
      entry_o.kind  = KIND_DIRECT;
      entry_o.level = cfg_i.out_high;
    end else begin
      entry_o.kind = KIND_RAMP;
    end
  end

  assign queue_push_o = push_i && !queue_full_i;

endmodule

`default_nettype wire

// ===== rtl/csp_fifo.sv =====
// ----------------------------------------------------------------------------
// csp_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire csp_pkg::csp_entry_t entry_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output csp_pkg::csp_entry_t      entry_o
);
  import csp_pkg::*;

  csp_entry_t          slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d;
  logic [QUEUE_AW-1:0] rd_q, rd_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csp_back.sv =====
// ----------------------------------------------------------------------------
// csp_back
// Execute queued items: palette writes, ramp division, palette lookup, output.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                palette_on_i,
  input  wire logic                queue_empty_i,
  input  wire csp_pkg::csp_entry_t entry_i,
  output logic                     queue_pop_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output csp_pkg::csp_out_t        item_o
);
  import csp_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_LEVEL = 3'd2;
  localparam logic [2:0] ST_MAP   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [QUOT_BITS-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [7:0]           ol_q, ol_d;
  logic [7:0]           level_q, level_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  csp_out_t             out_item_q, out_item_d;

  logic [SUM_W-1:0]     dvs_shift;
  logic [SUM_W:0]       trial;
  logic                 take;
  logic signed [10:0]   ramp_sum;
  logic                 out_free;
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [31:0]          rd_entry;
  logic [23:0]          ram_rdata;

  assign dvs_shift = SUM_W'(dvs_q) << cnt_q;
  assign trial     = {1'b0, rem_q} - {1'b0, dvs_shift};
  assign take      = !trial[SUM_W];
  assign ramp_sum  = $signed(11'(ol_q)) + $signed(11'(quot_q)) - $signed(11'(LEVEL_MAX));
  assign out_free  = !out_valid_q || pop_i;

  // Saturate the level onto the last palette entry
  assign rd_entry  = (32'(level_q) >= PALETTE_ENTRIES) ? 32'(PALETTE_ENTRIES - 1)
                                                       : 32'(level_q);
  assign ram_raddr = AW'(rd_entry);
  assign ram_waddr = AW'(entry_i.pal_index);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    ol_d        = ol_q;
    level_d     = level_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !pop_i;
    out_item_d  = out_item_q;
    queue_pop_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i) begin
          queue_pop_o = 1'b1;
          last_d      = entry_i.last;
          level_d     = entry_i.level;
          case (entry_i.kind)
            KIND_WRITE: begin
              ram_we = (32'(entry_i.pal_index) < PALETTE_ENTRIES);
            end
            KIND_RAMP: begin
              rem_d   = entry_i.sum;
              dvs_d   = entry_i.divisor;
              ol_d    = entry_i.out_low;
              quot_d  = '0;
              cnt_d   = CNT_W'(QUOT_BITS - 1);
              state_d = ST_DIV;
            end
            default: begin
              state_d = ST_MAP;
            end
          endcase
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle, most significant first
        quot_d = {quot_q[QUOT_BITS-2:0], take};
        if (take) begin
          rem_d = trial[SUM_W-1:0];
        end
        if (cnt_q == '0) begin
          state_d = ST_LEVEL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_LEVEL: begin
        // Remove the bias and clamp to the level range
        if (ramp_sum < 0) begin
          level_d = '0;
        end else if (ramp_sum > $signed(11'(LEVEL_MAX))) begin
          level_d = LEVEL_MAX;
        end else begin
          level_d = ramp_sum[7:0];
        end
        state_d = ST_MAP;
      end
      ST_MAP: begin
        ram_re  = palette_on_i;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_item_d.out_last = last_q;
          if (palette_on_i) begin
            out_item_d.out_red   = ram_rdata[23:16];
            out_item_d.out_green = ram_rdata[15:8];
            out_item_d.out_blue  = ram_rdata[7:0];
          end else begin
            out_item_d.out_red   = level_q;
            out_item_d.out_green = level_q;
            out_item_d.out_blue  = level_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    quot_q     <= quot_d;
    cnt_q      <= cnt_d;
    ol_q       <= ol_d;
    level_q    <= level_d;
    last_q     <= last_d;
    out_item_q <= out_item_d;
  end

  csp_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (entry_i.pal_rgb),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign empty_o = !out_valid_q;
  assign item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/contrast_stretch_palette_mapper_core.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch_palette_mapper_core
// Window contrast stretch of gray pixels with optional RGB palette lookup.
// ----------------------------------------------------------------------------
// Input: push an item while full is low; each item is a pixel or a palette
// write (command high). Output: while empty is low the oldest result sits on
// out_item_o; pop takes it. Only pixels produce a transaction.
// Configuration: cfg_valid_i/cfg_ready_o write one register by index; ready
// is always high. Write only while the block is idle.
// Flow: the front classifies each item and queues it (two entries). The
// back takes one queued item at a time. A palette write is done as it
// leaves the queue. A pixel outside the window, or with contrast off, goes
// through the map step (palette read) and the out step to the output
// register; a pixel inside the window first passes the one-bit-per-cycle
// ramp divider (9 steps) and bias removal, then takes the same two steps.
// Stall: a waiting result is held; palette writes ahead of the next pixel
// still retire, then the back finishes that pixel and holds it, the queue
// fills, and full rises.
// Reset: registers return to contrast off, window 0..255 onto 0..255,
// palette off; queue and output empty. The palette has no reset; read only
// entries that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module contrast_stretch_palette_mapper_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire csp_pkg::csp_in_t                     in_item_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output csp_pkg::csp_out_t                         out_item_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [csp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [csp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import csp_pkg::*;

  csp_cfg_t   cfg_q, cfg_d;
  logic       queue_push;
  logic       queue_pop;
  logic       queue_full;
  logic       queue_empty;
  csp_entry_t front_entry;
  csp_entry_t back_entry;

  assign cfg_ready_o = 1'b1;

  // Register file: drop writes to unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CONTRAST_ON:   cfg_d.contrast_on   = cfg_data_i[0];
        CFG_CONTRAST_LOW:  cfg_d.contrast_low  = cfg_data_i;
        CFG_CONTRAST_HIGH: cfg_d.contrast_high = cfg_data_i;
        CFG_OUT_LOW:       cfg_d.out_low       = cfg_data_i;
        CFG_OUT_HIGH:      cfg_d.out_high      = cfg_data_i;
        CFG_PALETTE_ON:    cfg_d.palette_on    = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contrast_on   <= 1'b0;
      cfg_q.contrast_low  <= 8'd0;
      cfg_q.contrast_high <= LEVEL_MAX;
      cfg_q.out_low       <= 8'd0;
      cfg_q.out_high      <= LEVEL_MAX;
      cfg_q.palette_on    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and precompute the ramp operands
  csp_front u_front (
    .push_i       (push),
    .item_i       (in_item_i),
    .cfg_i        (cfg_q),
    .queue_full_i (queue_full),
    .queue_push_o (queue_push),
    .entry_o      (front_entry)
  );

  assign full = queue_full;

  // Queue: decouple acceptance from execution
  csp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .entry_i (front_entry),
    .pop_i   (queue_pop),
    .full_o  (queue_full),
    .empty_o (queue_empty),
    .entry_o (back_entry)
  );

  // Back: execute writes, divide, look up, hold the result
  csp_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .palette_on_i  (cfg_q.palette_on),
    .queue_empty_i (queue_empty),
    .entry_i       (back_entry),
    .queue_pop_o   (queue_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .item_o        (out_item_o)
  );

endmodule

`default_nettype wire
